### src/mwt_pkg.sv
// Package for the weight-transposed matrix multiply unit: word types, field widths,
// register indexes and the register clamp function. No dependencies.
package mwt_pkg;

   localparam int VALUE_W     = 16;
   localparam int PROD_W      = 32;
   localparam int DOT_W       = 40;
   localparam int ROW_W       = 12;
   localparam int COL_W       = 6;
   localparam int DEPTH_W     = 6;
   localparam int ROWS_REG_W  = 13;
   localparam int COLS_REG_W  = 7;
   localparam int DEPTH_REG_W = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_MAX_DEPTH = 64;
   localparam int DEF_MAX_ROWS  = 4096;

   localparam int ROWS_RESET  = 4096;
   localparam int COLS_RESET  = 64;
   localparam int DEPTH_RESET = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH = 2'd2;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [COL_W-1:0]          col_index;
      logic [DEPTH_W-1:0]        depth_index;
      logic signed [VALUE_W-1:0] value;
   } mwt_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row_index;
      logic [COL_W-1:0]        out_col;
      logic signed [DOT_W-1:0] dot;
      logic                    last_of_row;
   } mwt_rsp_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic mul;
      logic acc;
      logic clr;
      logic load;
      logic shift;
   } mwt_cell_ctl_type;

   function automatic int addr_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] top);
      logic [31:0] r;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > top) begin
         r = top;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### src/mwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/mwt_cell.sv
// One output column: weight RAM, multiplier, exact accumulator and a result
// shift stage chained to its neighbour. Depends on mwt_pkg and mwt_ram.
module mwt_cell #(
   parameter int MAX_DEPTH = mwt_pkg::DEF_MAX_DEPTH,
   localparam int ADDR_W = mwt_pkg::addr_width(MAX_DEPTH)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mwt_pkg::mwt_cell_ctl_type                ctl,
   input  logic [ADDR_W-1:0]                        addr,
   input  logic signed [mwt_pkg::VALUE_W-1:0]       wdata,
   input  logic signed [mwt_pkg::VALUE_W-1:0]       value,
   input  logic signed [mwt_pkg::DOT_W-1:0]         chain_in,
   output logic signed [mwt_pkg::DOT_W-1:0]         chain_out
);
   import mwt_pkg::*;

   logic [VALUE_W-1:0]      rdata;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [DOT_W-1:0]  acc_ff;
   logic signed [DOT_W-1:0]  acc_in;
   logic signed [DOT_W-1:0]  out_ff;
   logic signed [DOT_W-1:0]  out_in;
   logic signed [DOT_W-1:0]  base;
   logic signed [DOT_W-1:0]  addend;

   mwt_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_DEPTH)
   ) u_ram (
      .clock(clock),
      .we(ctl.wr),
      .waddr(addr),
      .wdata(wdata),
      .re(ctl.rd),
      .raddr(addr),
      .rdata(rdata)
   );

   always_comb begin
      prod_in = value * $signed(rdata);
      base    = ctl.clr ? '0 : acc_ff;
      addend  = ctl.acc ? {{(DOT_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff} : '0;
      acc_in  = base + addend;
      out_in  = out_ff;
      if (ctl.load) begin
         out_in = acc_in;
      end else if (ctl.shift) begin
         out_in = chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.acc || ctl.clr) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      out_ff <= out_in;
   end

   assign chain_out = out_ff;

endmodule

### src/matmul_weights_transposed_unit.sv
// Top level of the weight-transposed matrix multiply: sequencer, registers and
// the row of column cells. Depends on mwt_pkg, mwt_cell and mwt_ram.
//
// Weight-stationary C = A x B^T with one cell per output column. A weight word
// (func 0) is written as it is taken. A data word (func 1) is handled in order: weight read
// from every cell's RAM as the word is taken, multiply, accumulate, then back to
// idle. The word at depth depth_in_use-1 instead unloads the row through the cell
// chain, one result per cycle while rsp_stall is low.
// The output register holds the last result while the next word is taken.
// Weights read before being written give undefined results.
module matmul_weights_transposed_unit #(
   parameter int MAX_COLS  = mwt_pkg::DEF_MAX_COLS,
   parameter int MAX_DEPTH = mwt_pkg::DEF_MAX_DEPTH,
   parameter int MAX_ROWS  = mwt_pkg::DEF_MAX_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mwt_pkg::mwt_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mwt_pkg::mwt_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mwt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mwt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mwt_pkg::*;

   localparam int ADDR_W      = addr_width(MAX_DEPTH);
   localparam int COLS_CNT_W  = $clog2(MAX_COLS + 1);
   localparam int DEPTH_CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int ROWS_CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int ROW_CTR_W   = addr_width(MAX_ROWS);
   localparam logic [31:0] ROWS_INIT  = clamp_reg(32'(ROWS_RESET), 32'(MAX_ROWS));
   localparam logic [31:0] COLS_INIT  = clamp_reg(32'(COLS_RESET), 32'(MAX_COLS));
   localparam logic [31:0] DEPTH_INIT = clamp_reg(32'(DEPTH_RESET), 32'(MAX_DEPTH));

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_ACC   = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                     clr_ff, clr_in;
   logic                     last_ff, last_in;
   logic [COLS_CNT_W-1:0]    drain_cnt_ff, drain_cnt_in;
   logic [ROW_CTR_W-1:0]     row_ff, row_in;
   logic [ROWS_CNT_W-1:0]    rows_ff, rows_in;
   logic [COLS_CNT_W-1:0]    cols_ff, cols_in;
   logic [DEPTH_CNT_W-1:0]   depth_ff, depth_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mwt_rsp_type              rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     load_go;
   logic                     data_go;
   logic                     drain_fire;
   logic                     drain_last;
   logic                     csr_write;
   logic [ADDR_W-1:0]        addr;
   logic signed [DOT_W-1:0]  chain [MAX_COLS];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_go    = req_accept && (req_data.func == FUNC_LOAD)
                       && (32'(req_data.depth_index) < 32'(MAX_DEPTH));
   assign data_go    = req_accept && (req_data.func == FUNC_DATA)
                       && (32'(req_data.depth_index) < 32'(depth_ff));
   assign drain_fire = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign drain_last = (32'(drain_cnt_ff) + 32'd1 == 32'(cols_ff));
   assign addr       = ADDR_W'(req_data.depth_index);
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      mwt_cell_ctl_type       ctl;
      logic signed [DOT_W-1:0] nb;

      always_comb begin
         ctl.rd    = data_go;
         ctl.wr    = load_go && (32'(req_data.col_index) == 32'(i));
         ctl.mul   = (state_ff == ST_MUL);
         ctl.acc   = (state_ff == ST_ACC) && (32'(i) < 32'(cols_ff));
         ctl.clr   = (state_ff == ST_ACC) && clr_ff;
         ctl.load  = (state_ff == ST_ACC) && last_ff;
         ctl.shift = drain_fire;
      end

      if (i == MAX_COLS - 1) begin : g_end
         assign nb = '0;
      end else begin : g_mid
         assign nb = chain[i+1];
      end

      mwt_cell #(
         .MAX_DEPTH(MAX_DEPTH)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .addr(addr),
         .wdata(req_data.value),
         .value(val_ff),
         .chain_in(nb),
         .chain_out(chain[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      clr_in       = clr_ff;
      last_in      = last_ff;
      drain_cnt_in = drain_cnt_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (data_go) begin
               val_in   = req_data.value;
               clr_in   = (req_data.depth_index == '0);
               last_in  = (32'(req_data.depth_index) + 32'd1 == 32'(depth_ff));
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = last_ff ? ST_DRAIN : ST_IDLE;
         end
         ST_DRAIN: begin
            if (drain_fire) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.row_index   = ROW_W'(row_ff);
               rsp_data_in.out_col     = COL_W'(drain_cnt_ff);
               rsp_data_in.dot         = chain[0];
               rsp_data_in.last_of_row = drain_last;
               drain_cnt_in            = drain_cnt_ff + 1'b1;
               if (drain_last) begin
                  drain_cnt_in = '0;
                  state_in     = ST_IDLE;
                  if (32'(row_ff) + 32'd1 >= 32'(rows_ff)) begin
                     row_in = '0;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      depth_in = depth_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROWS: begin
               rows_in = ROWS_CNT_W'(clamp_reg(32'(csr_wdata[ROWS_REG_W-1:0]),
                                               32'(MAX_ROWS)));
            end
            CSR_COLS: begin
               cols_in = COLS_CNT_W'(clamp_reg(32'(csr_wdata[COLS_REG_W-1:0]),
                                               32'(MAX_COLS)));
            end
            CSR_DEPTH: begin
               depth_in = DEPTH_CNT_W'(clamp_reg(32'(csr_wdata[DEPTH_REG_W-1:0]),
                                                 32'(MAX_DEPTH)));
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_cnt_ff <= '0;
         row_ff       <= '0;
         rows_ff      <= ROWS_CNT_W'(ROWS_INIT);
         cols_ff      <= COLS_CNT_W'(COLS_INIT);
         depth_ff     <= DEPTH_CNT_W'(DEPTH_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_cnt_ff <= drain_cnt_in;
         row_ff       <= row_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      clr_ff      <= clr_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      drain_cnt_ff < cols_ff)
      else $error("unload count beyond column count");

   a_row_end_idle: assert property (@(posedge clock) disable iff (reset)
      (drain_fire && drain_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after row end");

   a_word_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result word raised outside unload");
`endif

endmodule

### test/matmul_weights_transposed_unit_tb.sv
// Self-checking bench for matmul_weights_transposed_unit: random weight and data words,
// results predicted per column. Depends on mwt_pkg and the unit itself.
module matmul_weights_transposed_unit_tb;
   import mwt_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   class mwt_dot_predictor;
      shortint     weight_mem [DEF_MAX_COLS][DEF_MAX_DEPTH];
      bit          loaded [DEF_MAX_COLS][DEF_MAX_DEPTH];
      longint      col_sums [DEF_MAX_COLS];
      int unsigned row_ctr;
      int unsigned rows_lim;
      int unsigned cols_lim;
      int unsigned depth_lim;
      mwt_rsp_type expected_dots [$];
      int unsigned mismatches;

      function new();
         rows_lim   = ROWS_RESET;
         cols_lim   = COLS_RESET;
         depth_lim  = DEPTH_RESET;
         row_ctr    = 0;
         mismatches = 0;
         foreach (col_sums[c]) col_sums[c] = 0;
      endfunction

      function int unsigned bounded(int unsigned v, int unsigned top);
         if (v == 0) return 1;
         if (v > top) return top;
         return v;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ROWS:  rows_lim  = bounded(data[ROWS_REG_W-1:0], DEF_MAX_ROWS);
            CSR_COLS:  cols_lim  = bounded(data[COLS_REG_W-1:0], DEF_MAX_COLS);
            CSR_DEPTH: depth_lim = bounded(data[DEPTH_REG_W-1:0], DEF_MAX_DEPTH);
            default: ;
         endcase
      endfunction

      function void take_word(mwt_req_type w);
         int unsigned d;
         int          c;
         mwt_rsp_type r;
         d = w.depth_index;
         if (w.func == FUNC_LOAD) begin
            weight_mem[w.col_index][d] = w.value;
            loaded[w.col_index][d]     = 1'b1;
            return;
         end
         if (d == 0) foreach (col_sums[k]) col_sums[k] = 0;
         if (d >= depth_lim) return;
         for (c = 0; c < cols_lim; c++)
            col_sums[c] += longint'($signed(w.value)) * longint'(weight_mem[c][d]);
         if (d + 1 == depth_lim) begin
            for (c = 0; c < cols_lim; c++) begin
               r.row_index   = row_ctr[ROW_W-1:0];
               r.out_col     = c[COL_W-1:0];
               r.dot         = col_sums[c][DOT_W-1:0];
               r.last_of_row = (c + 1 == cols_lim);
               expected_dots.push_back(r);
            end
            row_ctr++;
            if (row_ctr >= rows_lim) row_ctr = 0;
         end
      endfunction

      function void note_fault(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_dot(mwt_rsp_type got);
         mwt_rsp_type want;
         if (expected_dots.size() == 0) begin
            note_fault($sformatf("unexpected result: row %0d col %0d dot %0d last %0b",
                                 got.row_index, got.out_col, $signed(got.dot),
                                 got.last_of_row));
            return;
         end
         want = expected_dots.pop_front();
         if (got.row_index !== want.row_index || got.out_col !== want.out_col ||
             got.dot !== want.dot || got.last_of_row !== want.last_of_row)
            note_fault($sformatf({"result mismatch: expected row %0d col %0d dot %0d last %0b,",
                                  " got row %0d col %0d dot %0d last %0b"},
                                 want.row_index, want.out_col, $signed(want.dot),
                                 want.last_of_row, got.row_index, got.out_col,
                                 $signed(got.dot), got.last_of_row));
      endfunction

      function int unsigned pending();
         return expected_dots.size();
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   mwt_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   mwt_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned      idle_pct  = 36;
   int unsigned      stall_pct = 36;
   mwt_dot_predictor dots      = new();

   matmul_weights_transposed_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && !rsp_stall) dots.check_dot(rsp_data);
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9, 0))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input mwt_req_type w);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      dots.take_word(w);
   endtask

   task automatic load_weight(input int col, input int d, input logic [VALUE_W-1:0] v);
      mwt_req_type w;
      w.func        = FUNC_LOAD;
      w.col_index   = col[COL_W-1:0];
      w.depth_index = d[DEPTH_W-1:0];
      w.value       = v;
      send_word(w);
   endtask

   task automatic feed(input int d, input logic [VALUE_W-1:0] v);
      mwt_req_type w;
      int          c;
      // write any weight this word will read that has never been written
      if (d < dots.depth_lim)
         for (c = 0; c < dots.cols_lim; c++)
            if (!dots.loaded[c][d]) load_weight(c, d, pick_value());
      w.func        = FUNC_DATA;
      w.col_index   = COL_W'($urandom_range(DEF_MAX_COLS - 1, 0));
      w.depth_index = d[DEPTH_W-1:0];
      w.value       = v;
      send_word(w);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (dots.pending() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      dots.write_reg(idx, data);
   endtask

   task automatic run_phase(input int rows, input int cols, input int depth, input int words);
      int unsigned next_d;
      int unsigned roll;
      int          n;
      settle();
      set_reg(CSR_ROWS, CSR_DATA_W'(rows));
      set_reg(CSR_COLS, CSR_DATA_W'(cols));
      set_reg(CSR_DEPTH, CSR_DATA_W'(depth));
      next_d = 0;
      for (n = 0; n < words; n++) begin
         roll = $urandom_range(99, 0);
         if (roll < 80) begin
            feed(next_d, pick_value());
            next_d = (next_d + 1) % dots.depth_lim;
         end else if (roll < 87) begin
            load_weight($urandom_range(DEF_MAX_COLS - 1, 0), $urandom_range(DEF_MAX_DEPTH - 1, 0),
                        pick_value());
         end else if (roll < 91) begin
            feed((dots.depth_lim < DEF_MAX_DEPTH) ?
                 $urandom_range(DEF_MAX_DEPTH - 1, dots.depth_lim) :
                 $urandom_range(DEF_MAX_DEPTH - 1, 0), pick_value());
         end else if (roll < 98) begin
            feed($urandom_range(dots.depth_lim - 1, 0), pick_value());
            if ($urandom_range(1, 0)) next_d = 0;
         end else begin
            settle();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_reg(CSR_UNMAPPED, 13'h1FFF);
      set_reg(CSR_ROWS, 13'h1FFF);
      set_reg(CSR_ROWS, 13'd2);
      set_reg(CSR_COLS, 13'h1F80);
      set_reg(CSR_COLS, 13'd3);
      set_reg(CSR_DEPTH, 13'd0);
      load_weight(0, 0, 16'h8000);
      load_weight(1, 0, 16'h8000);
      load_weight(2, 0, 16'h7FFF);
      load_weight(63, 63, 16'h7FFF);
      load_weight(42, 21, 16'hFFFF);
      feed(0, 16'h8000);
      feed(0, 16'h7FFF);
      feed(0, 16'h0001);
      feed(63, 16'h1234);
      settle();
      set_reg(CSR_DEPTH, 13'd3);
      feed(1, 16'h7FFF);
      feed(0, 16'hFF00);
      feed(2, 16'h8000);
      feed(0, 16'h0100);
      feed(1, 16'h7FFF);
      feed(1, 16'h8000);
      feed(2, 16'h0003);
      settle();
      set_reg(CSR_ROWS, 13'd1);
      feed(0, 16'hFFFF);
      feed(1, 16'h0002);
      feed(2, 16'h8000);

      run_phase(4096, 1, 64, 70);
      run_phase(1, 1, 1, 30);
      idle_pct  = 0;
      stall_pct = 0;
      run_phase(5, 8, 4, 50);
      idle_pct  = 36;
      stall_pct = 36;
      run_phase(7, 64, 1, 40);
      run_phase($urandom_range(9, 1), $urandom_range(16, 1), $urandom_range(8, 1), 40);

      settle();
      repeat (100) @(posedge clock);
      if (dots.mismatches == 0 && dots.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### matmul_weights_transposed_unit.f
src/mwt_pkg.sv
src/mwt_ram.sv
src/mwt_cell.sv
src/matmul_weights_transposed_unit.sv
test/matmul_weights_transposed_unit_tb.sv
